>>> sv/lspfe_pkg.sv
package lspfe_pkg;

    // default sizes
    localparam int MAX_CITIES_DEF = 1024;
    localparam int MAX_LAYERS_DEF = 16;
    localparam int MAX_EDGES_DEF  = 4096;
    localparam int COST_BITS_DEF  = 16;

    // fixed field widths
    localparam int CITY_W   = 10;
    localparam int CCOUNT_W = 11;
    localparam int TICKET_W = 4;
    localparam int IN_COST_W = 16;
    localparam int OUT_W    = 26;
    localparam int DIST_W   = 27;

    localparam logic [DIST_W-1:0] OUT_MAX  = DIST_W'((64'd1 << OUT_W) - 64'd1);
    localparam logic [DIST_W-1:0] DIST_INF = DIST_W'(64'd1 << OUT_W);

    // register indexes on the config port
    typedef enum logic [1:0] {
        REG_CITY_COUNT   = 2'd0,
        REG_TICKET_LIMIT = 2'd1,
        REG_START_CITY   = 2'd2,
        REG_TARGET_CITY  = 2'd3
    } reg_idx_t;

    // controller states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WA,
        ST_EDGE_WB,
        ST_INIT,
        ST_POP,
        ST_POP_TAKE,
        ST_SD_RD,
        ST_SD_CMP,
        ST_HEAD_U,
        ST_PTR,
        ST_LINK_CHK,
        ST_LINK_GET,
        ST_REL_RD,
        ST_REL_CHK,
        ST_REL_NEXT,
        ST_SU_CHK,
        ST_SU_CMP,
        ST_SCAN_INIT,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_RES
    } state_t;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_HEAD_RD,
        OP_EDGE_WA,
        OP_EDGE_WB,
        OP_INIT,
        OP_POP_RD,
        OP_POP_TAKE,
        OP_SD_RD,
        OP_SD_CMP,
        OP_HEAD_U,
        OP_PTR,
        OP_LINK_RD,
        OP_LINK_GET,
        OP_REL_RD,
        OP_REL_CHK,
        OP_REL_NEXT,
        OP_SU_CHK,
        OP_SU_CMP,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_ACC,
        OP_RES
    } op_t;

    // datapath status back to the controller
    typedef struct packed {
        logic clr_last;
        logic edge_ok;
        logic last;
        logic heap_empty;
        logic more;
        logic sd_done;
        logic e_nil;
        logic rel_better;
        logic phase_paid;
        logic pos_zero;
        logic su_move;
        logic tgt_ok;
        logic scan_last;
        logic out_busy;
    } stat_t;

endpackage

>>> sv/layered_shortest_path_free_edges_top.sv
// channel   dir  handshake                 payload
// s_        in   s_tvalid/s_tready         tdata: city_a, city_b, route_cost; tlast: last_edge
// m_        out  m_tvalid/m_tready         tdata: shortest_cost; tuser: reachable, edge_overflow
// apb       in   psel/penable/pready       four config registers at byte 0, 4, 8, 12
//
// an edge transfer is an accept, one head read, and two list writes on the
// single write port of the adjacency memories
// after last_edge the search runs heap steps (read, compare, write);
// its length depends on the graph, and the result then waits in an output register
// after reset and after each result a clearing pass walks the node memories,
// all 2^(clog2(MAX_CITIES)+clog2(MAX_LAYERS)) entries (16384 by default), with s_tready low
// reset is synchronous, active low; m_ stalls hold the result, the pass runs on
module layered_shortest_path_free_edges_top #(
    parameter int MAX_CITIES = lspfe_pkg::MAX_CITIES_DEF,
    parameter int MAX_LAYERS = lspfe_pkg::MAX_LAYERS_DEF,
    parameter int MAX_EDGES  = lspfe_pkg::MAX_EDGES_DEF,
    parameter int COST_BITS  = lspfe_pkg::COST_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input edges
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // city_a[9:0], city_b[19:10], route_cost[35:20], zero pad
    input  logic        s_tlast,   // last_edge
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // shortest_cost[25:0], zero pad
    output logic [1:0]  m_tuser,   // reachable[0], edge_overflow[1]
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lspfe_pkg::*;

    // config registers
    logic [CCOUNT_W-1:0] city_count_reg;
    logic [TICKET_W-1:0] ticket_limit_reg;
    logic [CITY_W-1:0]   start_city_reg, target_city_reg;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            city_count_reg   <= CCOUNT_W'(1);
            ticket_limit_reg <= '0;
            start_city_reg   <= '0;
            target_city_reg  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_CITY_COUNT:   city_count_reg   <= pwdata[CCOUNT_W-1:0];
                REG_TICKET_LIMIT: ticket_limit_reg <= pwdata[TICKET_W-1:0];
                REG_START_CITY:   start_city_reg   <= pwdata[CITY_W-1:0];
                REG_TARGET_CITY:  target_city_reg  <= pwdata[CITY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            REG_CITY_COUNT:   prdata = 32'(city_count_reg);
            REG_TICKET_LIMIT: prdata = 32'(ticket_limit_reg);
            REG_START_CITY:   prdata = 32'(start_city_reg);
            REG_TARGET_CITY:  prdata = 32'(target_city_reg);
            default:          prdata = '0;
        endcase
    end

    op_t              op;
    stat_t            stat;
    logic [OUT_W-1:0] out_cost;
    logic             out_reach, out_ovf;

    lspfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .op       (op)
    );

    lspfe_dpath #(
        .MAX_CITIES (MAX_CITIES),
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_EDGES  (MAX_EDGES),
        .COST_BITS  (COST_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (op),
        .stat         (stat),
        .city_count   (city_count_reg),
        .ticket_limit (ticket_limit_reg),
        .start_city   (start_city_reg),
        .target_city  (target_city_reg),
        .in_city_a    (s_tdata[9:0]),
        .in_city_b    (s_tdata[19:10]),
        .in_cost      (s_tdata[35:20]),
        .in_last      (s_tlast),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_cost     (out_cost),
        .out_reach    (out_reach),
        .out_ovf      (out_ovf)
    );

    // result packing
    assign m_tdata = {{(32 - OUT_W){1'b0}}, out_cost};
    assign m_tuser = {out_ovf, out_reach};

endmodule

>>> sv/lspfe_ctrl.sv
module lspfe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lspfe_pkg::stat_t  stat,
    output lspfe_pkg::op_t    op
);
    import lspfe_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                op = OP_CLEAR;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = ST_EDGE_RD;
                end
            end
            ST_EDGE_RD: begin
                op = OP_HEAD_RD;
                if (stat.edge_ok) state_next = ST_EDGE_WA;
                else              state_next = stat.last ? ST_INIT : ST_IDLE;
            end
            ST_EDGE_WA: begin
                op         = OP_EDGE_WA;
                state_next = ST_EDGE_WB;
            end
            ST_EDGE_WB: begin
                op         = OP_EDGE_WB;
                state_next = stat.last ? ST_INIT : ST_IDLE;
            end
            ST_INIT: begin
                op         = OP_INIT;
                state_next = ST_POP;
            end
            ST_POP: begin
                if (stat.heap_empty) begin
                    state_next = ST_SCAN_INIT;
                end else begin
                    op         = OP_POP_RD;
                    state_next = ST_POP_TAKE;
                end
            end
            ST_POP_TAKE: begin
                op         = OP_POP_TAKE;
                state_next = stat.more ? ST_SD_RD : ST_HEAD_U;
            end
            ST_SD_RD: begin
                op         = OP_SD_RD;
                state_next = ST_SD_CMP;
            end
            ST_SD_CMP: begin
                op         = OP_SD_CMP;
                state_next = stat.sd_done ? ST_HEAD_U : ST_SD_RD;
            end
            ST_HEAD_U: begin
                op         = OP_HEAD_U;
                state_next = ST_PTR;
            end
            ST_PTR: begin
                op         = OP_PTR;
                state_next = ST_LINK_CHK;
            end
            ST_LINK_CHK: begin
                if (stat.e_nil) begin
                    state_next = ST_POP;
                end else begin
                    op         = OP_LINK_RD;
                    state_next = ST_LINK_GET;
                end
            end
            ST_LINK_GET: begin
                op         = OP_LINK_GET;
                state_next = ST_REL_RD;
            end
            ST_REL_RD: begin
                op         = OP_REL_RD;
                state_next = ST_REL_CHK;
            end
            ST_REL_CHK: begin
                op         = OP_REL_CHK;
                state_next = stat.rel_better ? ST_SU_CHK : ST_REL_NEXT;
            end
            ST_REL_NEXT: begin
                op         = OP_REL_NEXT;
                state_next = stat.phase_paid ? ST_LINK_CHK : ST_REL_RD;
            end
            ST_SU_CHK: begin
                op         = OP_SU_CHK;
                state_next = stat.pos_zero ? ST_REL_NEXT : ST_SU_CMP;
            end
            ST_SU_CMP: begin
                op         = OP_SU_CMP;
                state_next = stat.su_move ? ST_SU_CHK : ST_REL_NEXT;
            end
            ST_SCAN_INIT: begin
                op         = OP_SCAN_INIT;
                state_next = stat.tgt_ok ? ST_SCAN_RD : ST_RES;
            end
            ST_SCAN_RD: begin
                op         = OP_SCAN_RD;
                state_next = ST_SCAN_ACC;
            end
            ST_SCAN_ACC: begin
                op         = OP_SCAN_ACC;
                state_next = stat.scan_last ? ST_RES : ST_SCAN_RD;
            end
            ST_RES: begin
                if (!stat.out_busy) begin
                    op         = OP_RES;
                    state_next = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> sv/lspfe_dpath.sv
module lspfe_dpath #(
    parameter int MAX_CITIES = lspfe_pkg::MAX_CITIES_DEF,
    parameter int MAX_LAYERS = lspfe_pkg::MAX_LAYERS_DEF,
    parameter int MAX_EDGES  = lspfe_pkg::MAX_EDGES_DEF,
    parameter int COST_BITS  = lspfe_pkg::COST_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lspfe_pkg::op_t                     op,
    output lspfe_pkg::stat_t                   stat,
    input  logic [lspfe_pkg::CCOUNT_W-1:0]     city_count,
    input  logic [lspfe_pkg::TICKET_W-1:0]     ticket_limit,
    input  logic [lspfe_pkg::CITY_W-1:0]       start_city,
    input  logic [lspfe_pkg::CITY_W-1:0]       target_city,
    input  logic [lspfe_pkg::CITY_W-1:0]       in_city_a,
    input  logic [lspfe_pkg::CITY_W-1:0]       in_city_b,
    input  logic [lspfe_pkg::IN_COST_W-1:0]    in_cost,
    input  logic                               in_last,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [lspfe_pkg::OUT_W-1:0]        out_cost,
    output logic                               out_reach,
    output logic                               out_ovf
);
    import lspfe_pkg::*;

    localparam int CB       = $clog2(MAX_CITIES);
    localparam int LYW      = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int NB       = CB + LYW;
    localparam int NSZ      = 1 << NB;
    localparam int LINK_CAP = 2 * MAX_EDGES;
    localparam int LB       = $clog2(LINK_CAP);
    localparam int PW       = LB + 1;
    localparam int HW       = NB + 1;
    localparam int KW       = DIST_W + NB;
    localparam int LW       = PW + CB + COST_BITS;
    localparam int SUMW     = ((DIST_W > COST_BITS) ? DIST_W : COST_BITS) + 1;

    // memories
    logic [PW-1:0]     head_mem [MAX_CITIES];
    logic [LW-1:0]     link_mem [LINK_CAP];
    logic [DIST_W-1:0] best_mem [NSZ];
    logic [HW-1:0]     hidx_mem [NSZ];
    logic [KW-1:0]     heap_mem [NSZ];

    // memory ports
    logic              head_we, link_we, best_we, hidx_we, heap_we;
    logic [CB-1:0]     head_wa, head_ra, head_rb;
    logic [PW-1:0]     head_wd, hrd_a, hrd_b;
    logic [LB-1:0]     link_wa, link_ra;
    logic [LW-1:0]     link_wd, lrd;
    logic [NB-1:0]     best_wa, best_ra, hidx_wa, hidx_ra;
    logic [DIST_W-1:0] best_wd, brd;
    logic [HW-1:0]     hidx_wd, xrd;
    logic [NB-1:0]     heap_wa, heap_ra, heap_rb;
    logic [KW-1:0]     heap_wd, prd_a, prd_b;

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        hrd_a <= head_mem[head_ra];
        hrd_b <= head_mem[head_rb];
    end

    always_ff @(posedge aclk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        lrd <= link_mem[link_ra];
    end

    always_ff @(posedge aclk) begin
        if (best_we) best_mem[best_wa] <= best_wd;
        brd <= best_mem[best_ra];
    end

    always_ff @(posedge aclk) begin
        if (hidx_we) hidx_mem[hidx_wa] <= hidx_wd;
        xrd <= hidx_mem[hidx_ra];
    end

    always_ff @(posedge aclk) begin
        if (heap_we) heap_mem[heap_wa] <= heap_wd;
        prd_a <= heap_mem[heap_ra];
        prd_b <= heap_mem[heap_rb];
    end

    // registers
    logic [CITY_W-1:0]    a_reg, a_next, b_reg, b_next;
    logic [COST_BITS-1:0] c_reg, c_next;
    logic                 last_reg, last_next;
    logic [PW-1:0]        cnt_reg, cnt_next, hb_reg, hb_next, e_reg, e_next;
    logic                 ovf_reg, ovf_next;
    logic [NB-1:0]        clr_reg, clr_next;
    logic [HW-1:0]        size_reg, size_next;
    logic [KW-1:0]        ukey_reg, ukey_next, skey_reg, skey_next;
    logic [NB-1:0]        pos_reg, pos_next, rnode_reg, rnode_next;
    logic [CB-1:0]        v_reg, v_next;
    logic [COST_BITS-1:0] vcost_reg, vcost_next;
    logic [DIST_W-1:0]    rd_reg, rd_next, best_reg, best_next;
    logic                 phase_reg, phase_next;
    logic [LYW-1:0]       i_reg, i_next;
    logic                 oval_reg, oval_next;
    logic [OUT_W-1:0]     ocost_reg, ocost_next;
    logic                 oreach_reg, oreach_next, oovf_reg, oovf_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            clr_reg  <= '0;
            size_reg <= '0;
            oval_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            clr_reg  <= clr_next;
            size_reg <= size_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        last_reg   <= last_next;
        hb_reg     <= hb_next;
        e_reg      <= e_next;
        ukey_reg   <= ukey_next;
        skey_reg   <= skey_next;
        pos_reg    <= pos_next;
        rnode_reg  <= rnode_next;
        v_reg      <= v_next;
        vcost_reg  <= vcost_next;
        rd_reg     <= rd_next;
        best_reg   <= best_next;
        phase_reg  <= phase_next;
        i_reg      <= i_next;
        ocost_reg  <= ocost_next;
        oreach_reg <= oreach_next;
        oovf_reg   <= oovf_next;
    end

    // derived values
    logic [15:0]          cities;
    logic [6:0]           lim;
    logic [CB-1:0]        a_c, b_c, start_c, tgt_c;
    logic                 edge_ok, start_ok, tgt_ok;
    logic [DIST_W-1:0]    du;
    logic [NB-1:0]        unode;
    logic [LYW-1:0]       ulayer;
    logic                 free_ok;
    logic [DIST_W-1:0]    paid_get, paid_reg;
    logic [HW+1:0]        lpos, rpos;
    logic                 lv, rv;
    logic [KW-1:0]        sd_key;
    logic [1:0]           sd_sel;
    logic [NB-1:0]        par;
    logic [CB-1:0]        lk_tgt;
    logic [COST_BITS-1:0] lk_cost;
    logic [PW-1:0]        lk_next;

    function automatic logic [DIST_W-1:0] paid_of(input logic [DIST_W-1:0] d,
                                                  input logic [COST_BITS-1:0] c);
        logic [SUMW-1:0] s;
        s = SUMW'(d) + SUMW'(c);
        if (s > SUMW'(OUT_MAX)) return OUT_MAX;
        return DIST_W'(s);
    endfunction

    always_comb begin
        cities = (16'(city_count) < 16'(MAX_CITIES)) ? 16'(city_count) : 16'(MAX_CITIES);
        lim = (7'(ticket_limit) < 7'(MAX_LAYERS - 1)) ? 7'(ticket_limit)
                                                     : 7'(MAX_LAYERS - 1);
        a_c      = CB'(16'(a_reg));
        b_c      = CB'(16'(b_reg));
        start_c  = CB'(16'(start_city));
        tgt_c    = CB'(16'(target_city));
        edge_ok  = (16'(a_reg) < cities) && (16'(b_reg) < cities)
                   && ((32'(cnt_reg) + 32'd2) <= 32'(LINK_CAP));
        start_ok = 16'(start_city) < cities;
        tgt_ok   = 16'(target_city) < cities;
        du       = ukey_reg[KW-1:NB];
        unode    = ukey_reg[NB-1:0];
        ulayer   = unode[LYW-1:0];
        free_ok  = 7'(ulayer) < lim;
        lk_next  = lrd[LW-1 -: PW];
        lk_tgt   = lrd[CB+COST_BITS-1 -: CB];
        lk_cost  = lrd[COST_BITS-1:0];
        paid_get = paid_of(du, lk_cost);
        paid_reg = paid_of(du, vcost_reg);
        lpos     = (HW+2)'(pos_reg) * (HW+2)'(2) + (HW+2)'(1);
        rpos     = lpos + (HW+2)'(1);
        lv       = lpos < (HW+2)'(size_reg);
        rv       = rpos < (HW+2)'(size_reg);
        sd_key   = skey_reg;
        sd_sel   = 2'd0;
        if (lv && (prd_a < sd_key)) begin
            sd_key = prd_a;
            sd_sel = 2'd1;
        end
        if (rv && (prd_b < sd_key)) begin
            sd_key = prd_b;
            sd_sel = 2'd2;
        end
        par = NB'((pos_reg - NB'(1)) >> 1);
    end

    always_comb begin
        stat.clr_last   = &clr_reg;
        stat.edge_ok    = edge_ok;
        stat.last       = last_reg;
        stat.heap_empty = size_reg == '0;
        stat.more       = size_reg > HW'(1);
        stat.sd_done    = sd_sel == 2'd0;
        stat.e_nil      = e_reg >= PW'(LINK_CAP);
        stat.rel_better = rd_reg < brd;
        stat.phase_paid = phase_reg;
        stat.pos_zero   = pos_reg == '0;
        stat.su_move    = skey_reg < prd_a;
        stat.tgt_ok     = tgt_ok;
        stat.scan_last  = 7'(i_reg) == lim;
        stat.out_busy   = oval_reg && !out_ready;
    end

    always_comb begin
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        hb_next     = hb_reg;
        e_next      = e_reg;
        ovf_next    = ovf_reg;
        clr_next    = clr_reg;
        size_next   = size_reg;
        ukey_next   = ukey_reg;
        skey_next   = skey_reg;
        pos_next    = pos_reg;
        rnode_next  = rnode_reg;
        v_next      = v_reg;
        vcost_next  = vcost_reg;
        rd_next     = rd_reg;
        best_next   = best_reg;
        phase_next  = phase_reg;
        i_next      = i_reg;
        ocost_next  = ocost_reg;
        oreach_next = oreach_reg;
        oovf_next   = oovf_reg;
        oval_next   = (oval_reg && out_ready) ? 1'b0 : oval_reg;

        head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0; head_rb = '0;
        link_we = 1'b0; link_wa = '0; link_wd = '0; link_ra = '0;
        best_we = 1'b0; best_wa = '0; best_wd = '0; best_ra = '0;
        hidx_we = 1'b0; hidx_wa = '0; hidx_wd = '0; hidx_ra = '0;
        heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = '0; heap_rb = '0;

        case (op)
            OP_CLEAR: begin
                best_we  = 1'b1;
                best_wa  = clr_reg;
                best_wd  = DIST_INF;
                hidx_we  = 1'b1;
                hidx_wa  = clr_reg;
                hidx_wd  = '0;
                head_we  = (NB+1)'(clr_reg) < (NB+1)'(MAX_CITIES);
                head_wa  = clr_reg[CB-1:0];
                head_wd  = PW'(LINK_CAP);
                clr_next = clr_reg + NB'(1);
            end
            OP_LOAD: begin
                a_next    = in_city_a;
                b_next    = in_city_b;
                c_next    = COST_BITS'(in_cost);
                last_next = in_last;
            end
            OP_HEAD_RD: begin
                head_ra = a_c;
                head_rb = b_c;
                if (!edge_ok) ovf_next = 1'b1;
            end
            OP_EDGE_WA: begin
                hb_next = hrd_b;
                link_we = 1'b1;
                link_wa = cnt_reg[LB-1:0];
                link_wd = {hrd_a, b_c, c_reg};
                head_we = 1'b1;
                head_wa = a_c;
                head_wd = cnt_reg;
            end
            OP_EDGE_WB: begin
                link_we  = 1'b1;
                link_wa  = LB'(cnt_reg + PW'(1));
                link_wd  = {(a_reg == b_reg) ? cnt_reg : hb_reg, a_c, c_reg};
                head_we  = 1'b1;
                head_wa  = b_c;
                head_wd  = cnt_reg + PW'(1);
                cnt_next = cnt_reg + PW'(2);
            end
            OP_INIT: begin
                if (start_ok) begin
                    best_we   = 1'b1;
                    best_wa   = {start_c, LYW'(0)};
                    best_wd   = '0;
                    heap_we   = 1'b1;
                    heap_wa   = '0;
                    heap_wd   = {DIST_W'(0), start_c, LYW'(0)};
                    hidx_we   = 1'b1;
                    hidx_wa   = {start_c, LYW'(0)};
                    hidx_wd   = HW'(1);
                    size_next = HW'(1);
                end else begin
                    size_next = '0;
                end
            end
            OP_POP_RD: begin
                heap_ra = '0;
                heap_rb = NB'(size_reg - HW'(1));
            end
            OP_POP_TAKE: begin
                ukey_next = prd_a;
                skey_next = prd_b;
                hidx_we   = 1'b1;
                hidx_wa   = prd_a[NB-1:0];
                hidx_wd   = '0;
                size_next = size_reg - HW'(1);
                pos_next  = '0;
            end
            OP_SD_RD: begin
                heap_ra = NB'(lpos);
                heap_rb = NB'(rpos);
            end
            OP_SD_CMP: begin
                heap_we = 1'b1;
                heap_wa = pos_reg;
                heap_wd = sd_key;
                hidx_we = 1'b1;
                hidx_wa = sd_key[NB-1:0];
                hidx_wd = HW'(pos_reg) + HW'(1);
                if (sd_sel == 2'd1) pos_next = NB'(lpos);
                if (sd_sel == 2'd2) pos_next = NB'(rpos);
            end
            OP_HEAD_U: begin
                head_ra = unode[NB-1:LYW];
            end
            OP_PTR: begin
                e_next = hrd_a;
            end
            OP_LINK_RD: begin
                link_ra = e_reg[LB-1:0];
            end
            OP_LINK_GET: begin
                v_next     = lk_tgt;
                vcost_next = lk_cost;
                e_next     = lk_next;
                if (free_ok) begin
                    rnode_next = {lk_tgt, LYW'(ulayer + LYW'(1))};
                    rd_next    = du;
                    phase_next = 1'b0;
                end else begin
                    rnode_next = {lk_tgt, ulayer};
                    rd_next    = paid_get;
                    phase_next = 1'b1;
                end
            end
            OP_REL_RD: begin
                best_ra = rnode_reg;
                hidx_ra = rnode_reg;
            end
            OP_REL_CHK: begin
                if (rd_reg < brd) begin
                    best_we   = 1'b1;
                    best_wa   = rnode_reg;
                    best_wd   = rd_reg;
                    skey_next = {rd_reg, rnode_reg};
                    if (xrd == '0) begin
                        pos_next  = NB'(size_reg);
                        size_next = size_reg + HW'(1);
                    end else begin
                        pos_next = NB'(xrd - HW'(1));
                    end
                end
            end
            OP_REL_NEXT: begin
                if (!phase_reg) begin
                    rnode_next = {v_reg, ulayer};
                    rd_next    = paid_reg;
                    phase_next = 1'b1;
                end
            end
            OP_SU_CHK: begin
                if (pos_reg == '0) begin
                    heap_we = 1'b1;
                    heap_wa = '0;
                    heap_wd = skey_reg;
                    hidx_we = 1'b1;
                    hidx_wa = skey_reg[NB-1:0];
                    hidx_wd = HW'(1);
                end else begin
                    heap_ra = par;
                end
            end
            OP_SU_CMP: begin
                heap_we = 1'b1;
                heap_wa = pos_reg;
                hidx_we = 1'b1;
                hidx_wd = HW'(pos_reg) + HW'(1);
                if (skey_reg < prd_a) begin
                    heap_wd  = prd_a;
                    hidx_wa  = prd_a[NB-1:0];
                    pos_next = par;
                end else begin
                    heap_wd = skey_reg;
                    hidx_wa = skey_reg[NB-1:0];
                end
            end
            OP_SCAN_INIT: begin
                best_next = DIST_INF;
                i_next    = '0;
            end
            OP_SCAN_RD: begin
                best_ra = {tgt_c, i_reg};
            end
            OP_SCAN_ACC: begin
                if (brd < best_reg) best_next = brd;
                i_next = i_reg + LYW'(1);
            end
            OP_RES: begin
                oval_next   = 1'b1;
                ocost_next  = (best_reg < DIST_INF) ? OUT_W'(best_reg) : '0;
                oreach_next = best_reg < DIST_INF;
                oovf_next   = ovf_reg;
                clr_next    = '0;
                cnt_next    = '0;
                ovf_next    = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign out_valid = oval_reg;
    assign out_cost  = ocost_reg;
    assign out_reach = oreach_reg;
    assign out_ovf   = oovf_reg;

endmodule
